FILE: design/thcr_pkg.sv
// Shared types, constants and register indexes of the temperature and humidity change reporter.
package thcr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TEMP_CAL    = 3'd0,
      REG_HUMI_CAL    = 3'd1,
      REG_TEMP_UPLOAD = 3'd2,
      REG_HUMI_UPLOAD = 3'd3,
      REG_TEMP_LINK   = 3'd4,
      REG_HUMI_LINK   = 3'd5
   } csr_index_type;

   localparam logic [14:0]        TEMP_GAIN   = 15'd17572;
   localparam logic signed [31:0] TEMP_OFFSET = 32'sd307036160;
   localparam logic [6:0]         HUMI_GAIN   = 7'd125;
   localparam logic signed [23:0] HUMI_OFFSET = 24'sd393216;
   localparam logic [16:0]        DIV10_RECIP = 17'd52429;

   localparam logic signed [13:0] TEMP_LO = -14'sd468;
   localparam logic signed [13:0] TEMP_HI = 14'sd1250;
   localparam logic signed [9:0]  HUMI_LO = 10'sd0;
   localparam logic signed [9:0]  HUMI_HI = 10'sd100;

   localparam logic [10:0] TEMP_UPLOAD_RST = 11'd10;
   localparam logic [6:0]  HUMI_UPLOAD_RST = 7'd5;
   localparam logic [10:0] TEMP_LINK_RST   = 11'd10;
   localparam logic [6:0]  HUMI_LINK_RST   = 7'd5;

   typedef struct packed {
      logic signed [10:0] temp_cal;
      logic signed [7:0]  humi_cal;
      logic [10:0]        temp_upload;
      logic [6:0]         humi_upload;
      logic [10:0]        temp_link;
      logic [6:0]         humi_link;
   } cfg_type;

   typedef struct packed {
      logic [15:0] raw_t;
      logic [13:0] raw_h;
      logic        mode;
      logic        link;
   } raw_type;

   typedef struct packed {
      logic signed [11:0] temp;
      logic [6:0]         humi;
      logic               mode;
      logic               link;
   } sample_type;

   typedef struct packed {
      logic [11:0] temp;
      logic [6:0]  humi;
      logic        upload;
      logic        temp_event;
      logic        humi_event;
   } result_type;

endpackage

FILE: design/thcr_cfg.sv
// Configuration register file of the change reporter.
module thcr_cfg
   import thcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_CAL:    cfg_in.temp_cal    = $signed(csr_data[10:0]);
            REG_HUMI_CAL:    cfg_in.humi_cal    = $signed(csr_data[7:0]);
            REG_TEMP_UPLOAD: cfg_in.temp_upload = csr_data[10:0];
            REG_HUMI_UPLOAD: cfg_in.humi_upload = csr_data[6:0];
            REG_TEMP_LINK:   cfg_in.temp_link   = csr_data[10:0];
            REG_HUMI_LINK:   cfg_in.humi_link   = csr_data[6:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_cal    <= '0;
         cfg_ff.humi_cal    <= '0;
         cfg_ff.temp_upload <= TEMP_UPLOAD_RST;
         cfg_ff.humi_upload <= HUMI_UPLOAD_RST;
         cfg_ff.temp_link   <= TEMP_LINK_RST;
         cfg_ff.humi_link   <= HUMI_LINK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/thcr_convert.sv
// Two-stage conversion of raw sensor codes to calibrated, clamped physical values.
module thcr_convert
   import thcr_pkg::*;
(
   input  logic       clock,
   input  logic       prod_load,
   input  logic       conv_load,
   input  raw_type    raw,
   input  cfg_type    cfg,
   output sample_type sample
);

   logic [30:0]        tp;
   logic [22:0]        hp;
   logic signed [31:0] tn_in;
   logic signed [23:0] hn_in;
   logic signed [31:0] tn_ff;
   logic signed [23:0] hn_ff;
   logic               mode_ff;
   logic               link_ff;

   logic [31:0]        tmag;
   logic [30:0]        tprod;
   logic [11:0]        tq;
   logic signed [13:0] t0;
   logic [23:0]        hmag;
   logic [6:0]         hq;
   logic signed [9:0]  h0;
   sample_type         sample_in;
   sample_type         sample_ff;

   always_comb begin
      tp    = {15'd0, raw.raw_t} * {16'd0, TEMP_GAIN};
      hp    = {7'd0, raw.raw_h, 2'b00} * {16'd0, HUMI_GAIN};
      tn_in = $signed({1'b0, tp}) - TEMP_OFFSET;
      hn_in = $signed({1'b0, hp}) - HUMI_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         tn_ff   <= tn_in;
         hn_ff   <= hn_in;
         mode_ff <= raw.mode;
         link_ff <= raw.link;
      end
   end

   // Quotients truncate toward zero, so the magnitude is divided and the sign put back.
   always_comb begin
      tmag  = tn_ff[31] ? 32'(-tn_ff) : 32'(tn_ff);
      tprod = {17'd0, tmag[29:16]} * {14'd0, DIV10_RECIP};
      tq    = tprod[30:19];
      t0    = (tn_ff[31] ? -$signed({2'b00, tq}) : $signed({2'b00, tq}))
              + 14'(cfg.temp_cal);
      hmag  = hn_ff[23] ? 24'(-hn_ff) : 24'(hn_ff);
      hq    = hmag[22:16];
      h0    = (hn_ff[23] ? -$signed({3'b000, hq}) : $signed({3'b000, hq}))
              + 10'(cfg.humi_cal);

      if (t0 <= TEMP_LO) begin
         sample_in.temp = TEMP_LO[11:0];
      end else if (t0 >= TEMP_HI) begin
         sample_in.temp = TEMP_HI[11:0];
      end else begin
         sample_in.temp = t0[11:0];
      end

      if (h0 <= HUMI_LO) begin
         sample_in.humi = HUMI_LO[6:0];
      end else if (h0 >= HUMI_HI) begin
         sample_in.humi = HUMI_HI[6:0];
      end else begin
         sample_in.humi = h0[6:0];
      end

      sample_in.mode = mode_ff;
      sample_in.link = link_ff;
   end

   always_ff @(posedge clock) begin
      if (conv_load) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

FILE: design/thcr_track.sv
// Previous-sample and drift tracking with upload and linkage decisions, plus the result register.
module thcr_track
   import thcr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  sample_type sample,
   input  cfg_type    cfg,
   output result_type result
);

   logic               mode_was_on_ff;
   logic [11:0]        prev_t_ff;
   logic [6:0]         prev_h_ff;
   logic [11:0]        drift_t_ff;
   logic [7:0]         drift_h_ff;
   result_type         result_ff;

   logic               rise;
   logic [11:0]        pt;
   logic [6:0]         ph;
   logic [11:0]        td;
   logic [7:0]         hd;
   logic [12:0]        dt;
   logic [12:0]        adt;
   logic [7:0]         dh;
   logic [7:0]         adh;
   logic [12:0]        td_sum;
   logic [11:0]        td_new;
   logic [11:0]        atd;
   logic [7:0]         hd_new;
   logic [7:0]         ahd;
   logic               t_fire;
   logic               h_fire;
   logic [11:0]        drift_t_in;
   logic [7:0]         drift_h_in;
   result_type         result_in;

   always_comb begin
      rise   = sample.mode & ~mode_was_on_ff;
      pt     = rise ? '0 : prev_t_ff;
      ph     = rise ? '0 : prev_h_ff;
      td     = rise ? '0 : drift_t_ff;
      hd     = rise ? '0 : drift_h_ff;

      dt     = {sample.temp[11], sample.temp} - {pt[11], pt};
      adt    = dt[12] ? -dt : dt;
      dh     = {1'b0, sample.humi} - {1'b0, ph};
      adh    = dh[7] ? -dh : dh;

      td_sum = {td[11], td} + dt;
      td_new = td_sum[11:0];
      atd    = td_new[11] ? -td_new : td_new;
      hd_new = hd + dh;
      ahd    = hd_new[7] ? -hd_new : hd_new;

      t_fire = atd >= {1'b0, cfg.temp_link};
      h_fire = ahd >= {1'b0, cfg.humi_link};
      drift_t_in = t_fire ? '0 : td_new;
      drift_h_in = h_fire ? '0 : hd_new;

      result_in.temp       = sample.temp;
      result_in.humi       = sample.humi;
      result_in.upload     = (adt >= {2'b00, cfg.temp_upload}) ||
                             (adh >= {1'b0, cfg.humi_upload});
      result_in.temp_event = t_fire & sample.mode & ~sample.temp[11] & sample.link;
      result_in.humi_event = h_fire & sample.mode & sample.link;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_was_on_ff <= 1'b0;
         prev_t_ff      <= '0;
         prev_h_ff      <= '0;
         drift_t_ff     <= '0;
         drift_h_ff     <= '0;
      end else if (load) begin
         mode_was_on_ff <= sample.mode;
         prev_t_ff      <= sample.temp;
         prev_h_ff      <= sample.humi;
         drift_t_ff     <= drift_t_in;
         drift_h_ff     <= drift_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: design/temp_humidity_change_reporter_unit.sv
// Top level of the temperature and humidity change reporter: pipeline control and ports.
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   raw codes, auto mode, linkage enable
//   rsp_      out         rsp_valid/rsp_stall   temperature, humidity, upload, link events
//   csr_      in          csr_valid/csr_ready   register index and write data
//
// A request is taken every cycle while req_stall is low and reaches rsp_ through the stages below.
// The stages are input register, product register, converted-sample register and result
// register; tracking state is updated when a sample enters the result register.
// Reset clears all valid bits, tracking state and the configuration registers to their reset
// values.
// A stall on rsp_ backs up through the stages and reaches req_stall in the same cycle.
module temp_humidity_change_reporter_unit
   import thcr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [15:0]            req_raw_temperature,
   input  logic [15:0]            req_raw_humidity,
   input  logic                   req_auto_mode_on,
   input  logic                   req_linkage_enabled,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [11:0]     rsp_temperature_tenths,
   output logic [6:0]             rsp_humidity_percent,
   output logic                   rsp_upload_request,
   output logic                   rsp_temp_link_event,
   output logic                   rsp_humi_link_event,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   raw_type    raw_ff;
   sample_type sample;
   result_type result;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, rsp_valid_in;
   logic adv1, adv2, adv3, adv4;

   always_comb begin
      adv4 = ~rsp_valid_ff | ~rsp_stall;
      adv3 = ~s3_valid_ff | adv4;
      adv2 = ~s2_valid_ff | adv3;
      adv1 = ~s1_valid_ff | adv2;

      s1_valid_in  = adv1 ? req_valid   : s1_valid_ff;
      s2_valid_in  = adv2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = adv3 ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = adv4 ? s3_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && adv1) begin
         raw_ff.raw_t <= req_raw_temperature;
         raw_ff.raw_h <= req_raw_humidity[15:2];
         raw_ff.mode  <= req_auto_mode_on;
         raw_ff.link  <= req_linkage_enabled;
      end
   end

   assign req_stall = ~adv1;

   thcr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   thcr_convert u_convert (
      .clock     (clock),
      .prod_load (adv2 & s1_valid_ff),
      .conv_load (adv3 & s2_valid_ff),
      .raw       (raw_ff),
      .cfg       (cfg),
      .sample    (sample)
   );

   thcr_track u_track (
      .clock  (clock),
      .reset  (reset),
      .load   (adv4 & s3_valid_ff),
      .sample (sample),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temperature_tenths = $signed(result.temp);
   assign rsp_humidity_percent   = result.humi;
   assign rsp_upload_request     = result.upload;
   assign rsp_temp_link_event    = result.temp_event;
   assign rsp_humi_link_event    = result.humi_event;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff))
      else $error("request stalled while the pipeline has room");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temperature_tenths >= -12'sd468 &&
                     rsp_temperature_tenths <= 12'sd1250))
      else $error("temperature result outside clamp range");

   a_humi_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_humidity_percent <= 7'd100))
      else $error("humidity result outside clamp range");

   a_temp_event_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_temp_link_event) |-> !rsp_temperature_tenths[11])
      else $error("temperature link event with negative temperature");

endmodule
